[rtl/plq_pkg.sv]
// Shared types and constants of the price level order queue.
// Used by the core and the port checker; no dependencies.
package plq_pkg;

	localparam int HANDLE_W    = 6;
	localparam int ID_W        = 32;
	localparam int PRICE_W     = 32;
	localparam int QTY_IN_W    = 32;
	localparam int TOTAL_W     = 38;
	localparam int COUNT_OUT_W = 7;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_ERASE = 2'd1,
		CMD_FILL  = 2'd2,
		CMD_POP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_PRICE     = 3'd1,
		ST_ZERO      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_UNFILLED  = 3'd4,
		ST_FULL      = 3'd5,
		ST_OVERFILL  = 3'd6,
		ST_BADHANDLE = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EVAL = 2'd1,
		S_DONE = 2'd2
	} state_t;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [ID_W-1:0]     order_id;
		logic [PRICE_W-1:0]  order_price;
		logic [QTY_IN_W-1:0] order_quantity;
		logic [HANDLE_W-1:0] slot_handle;
		logic [QTY_IN_W-1:0] take_quantity;
	} req_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [HANDLE_W-1:0]    new_handle;
		logic [TOTAL_W-1:0]     total_quantity;
		logic [COUNT_OUT_W-1:0] order_count;
		logic                   front_valid;
		logic [ID_W-1:0]        front_id;
		logic [QTY_IN_W-1:0]    front_remaining;
	} rsp_t;

endpackage

[rtl/price_level_order_queue_core.sv]
// Price level order queue core: linked list of order slots held in two slot RAMs.
// Depends on plq_pkg and plq_ram.
//
// The block keeps the time-ordered queue of resting orders at one price in CAPACITY
// slots: a link RAM (used flag, next slot) and a data RAM (previous slot, remaining
// quantity, order id), plus head, tail, free-list head, order count and running total
// in registers. Every request item (add, erase, fill, pop) gives exactly one response
// item. An item passes the idle, evaluate and done states: idle accepts it and issues
// the slot reads, evaluate checks the command and issues the first write-back, done
// writes the last slot word and loads the response register. The sequence follows from
// the registered read of the RAMs and the single write port of the link RAM, which takes
// up to two writes on an add or an unlink; no new item is taken before the last is done.
// A finished response waits in its output register while the next item is accepted;
// that item then completes only once the earlier response is taken. After reset no
// clearing pass runs: a count of slots ever handed out marks which slots still hold
// their reset chain. Handles and the order count are reported in 6 and 7 bits.
module price_level_order_queue_core #(
	parameter int CAPACITY = 64,
	parameter int QTY_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  plq_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output plq_pkg::rsp_t                rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [plq_pkg::PRICE_W-1:0]  cfg_data
);
	import plq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int QW = (QTY_BITS < QTY_IN_W) ? QTY_BITS : QTY_IN_W;
	localparam int AW = ((IW > HANDLE_W) ? IW : HANDLE_W) + 1;

	typedef struct packed {
		logic          used;
		logic [IW-1:0] nxt;
	} link_t;

	typedef struct packed {
		logic [IW-1:0]   prev;
		logic [QW-1:0]   rem;
		logic [ID_W-1:0] id;
	} data_t;

	typedef enum logic [1:0] {
		FR_KEEP = 2'd0,
		FR_SET  = 2'd1,
		FR_LOAD = 2'd2
	} front_src_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] new_handle;
		logic [IW-1:0]       head;
		logic [IW-1:0]       tail;
		logic [IW-1:0]       free_slot;
		logic [CW-1:0]       fresh;
		logic [CW-1:0]       count;
		logic [TOTAL_W-1:0]  total;
		front_src_t          front_src;
		logic [ID_W-1:0]     front_id;
		logic [QW-1:0]       front_rem;
		logic                lw_en;
		logic [IW-1:0]       lw_addr;
		link_t               lw_data;
		logic                dw_en;
		logic [IW-1:0]       dw_addr;
		data_t               dw_data;
		logic [IW-1:0]       nx;
	} plan_t;

	state_t              state_q, state_d;
	req_t                op_q;
	logic [PRICE_W-1:0]  level_q;
	logic [IW-1:0]       head_q, tail_q, free_q;
	logic [CW-1:0]       fresh_q, count_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [ID_W-1:0]     front_id_q, front_id_d;
	logic [QW-1:0]       front_rem_q, front_rem_d;
	logic                rsp_valid_q;
	rsp_t                rsp_q, rsp_d;
	plan_t               plan_q, ev;

	logic                link_we, data_we;
	logic [IW-1:0]       link_waddr, link_raddr, data_waddr, data_raddr;
	link_t               link_wdata, link_wmask, link_rd;
	data_t               data_wdata, data_wmask, data_rd;

	logic [AW-1:0]       hreq_ext, hop_ext;
	logic [IW-1:0]       hreq_idx, hop_idx, la_req, la_op, da_req;
	logic                hop_ok;
	logic                l_fresh, l_used;
	logic [IW-1:0]       l_next;

	logic                lw1_en, dw1_en;
	logic [IW-1:0]       lw1_addr, dw1_addr;
	link_t               lw1_data, lw1_mask;
	data_t               dw1_data, dw1_mask;

	logic [QW-1:0]       qty_m, fill_m, new_rem, sub_amt;
	logic                unlink, is_head, is_tail;
	logic [IW-1:0]       unl_slot, prev_v;
	logic                out_free, commit;

	// slot RAMs
	plq_ram #(.W($bits(link_t)), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wmask (link_wmask),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rd)
	);

	plq_ram #(.W($bits(data_t)), .DEPTH(CAPACITY)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wmask (data_wmask),
		.wdata (data_wdata),
		.raddr (data_raddr),
		.rdata (data_rd)
	);

	// decode handles and read addresses of the incoming and the held item
	assign hreq_ext = AW'(req.slot_handle);
	assign hreq_idx = hreq_ext[IW-1:0];
	assign hop_ext  = AW'(op_q.slot_handle);
	assign hop_idx  = hop_ext[IW-1:0];
	assign hop_ok   = hop_ext < AW'(CAPACITY);

	assign la_req = (req.cmd == CMD_ADD) ? free_q :
	                (req.cmd == CMD_ERASE) ? hreq_idx : head_q;
	assign da_req = (req.cmd == CMD_ERASE) ? hreq_idx : head_q;
	assign la_op  = (op_q.cmd == CMD_ADD) ? free_q :
	                (op_q.cmd == CMD_ERASE) ? hop_idx : head_q;

	// substitute the reset chain for slots never handed out
	assign l_fresh = CW'(la_op) >= fresh_q;
	assign l_used  = l_fresh ? 1'b0 : link_rd.used;
	assign l_next  = !l_fresh ? link_rd.nxt :
	                 (la_op == IW'(CAPACITY - 1)) ? '0 : la_op + IW'(1);

	assign qty_m   = op_q.order_quantity[QW-1:0];
	assign fill_m  = op_q.take_quantity[QW-1:0];
	assign new_rem = data_rd.rem - fill_m;

	// evaluate the held command against the slot words just read
	always_comb begin
		ev              = '0;
		ev.status       = ST_OK;
		ev.head         = head_q;
		ev.tail         = tail_q;
		ev.free_slot    = free_q;
		ev.fresh        = fresh_q;
		ev.count        = count_q;
		ev.total        = total_q;
		ev.front_src    = FR_KEEP;
		ev.front_id     = front_id_q;
		ev.front_rem    = front_rem_q;
		ev.lw_addr      = free_q;
		ev.dw_addr      = free_q;
		ev.nx           = l_next;
		lw1_en          = 1'b0;
		lw1_addr        = tail_q;
		lw1_data        = '0;
		lw1_mask        = '0;
		dw1_en          = 1'b0;
		dw1_addr        = l_next;
		dw1_data        = '0;
		dw1_mask        = '0;
		unlink          = 1'b0;
		unl_slot        = head_q;
		sub_amt         = '0;
		prev_v          = tail_q;
		case (cmd_t'(op_q.cmd))
			CMD_ADD: begin
				if (op_q.order_price != level_q) begin
					ev.status = ST_PRICE;
				end else if (qty_m == '0) begin
					ev.status = ST_ZERO;
				end else if (count_q == CW'(CAPACITY)) begin
					ev.status = ST_FULL;
				end else begin
					ev.free_slot = l_next;
					if (CW'(free_q) == fresh_q) begin
						ev.fresh = fresh_q + CW'(1);
					end
					if (count_q != '0) begin
						lw1_en       = 1'b1;
						lw1_addr     = tail_q;
						lw1_data.nxt = free_q;
						lw1_mask.nxt = '1;
						prev_v       = tail_q;
					end else begin
						ev.head      = free_q;
						prev_v       = '0;
						ev.front_src = FR_SET;
						ev.front_id  = op_q.order_id;
						ev.front_rem = qty_m;
					end
					ev.tail            = free_q;
					ev.count           = count_q + CW'(1);
					ev.total           = total_q + TOTAL_W'(qty_m);
					ev.new_handle      = HANDLE_W'(free_q);
					ev.lw_en           = 1'b1;
					ev.lw_addr         = free_q;
					ev.lw_data.used    = 1'b1;
					ev.lw_data.nxt     = '0;
					ev.dw_en           = 1'b1;
					ev.dw_addr         = free_q;
					ev.dw_data.prev    = prev_v;
					ev.dw_data.rem     = qty_m;
					ev.dw_data.id      = op_q.order_id;
				end
			end
			CMD_ERASE: begin
				if (!(hop_ok && l_used)) begin
					ev.status = ST_BADHANDLE;
				end else begin
					unlink   = 1'b1;
					unl_slot = hop_idx;
					sub_amt  = data_rd.rem;
				end
			end
			CMD_FILL: begin
				if (count_q == '0) begin
					ev.status = ST_EMPTY;
				end else if (fill_m > data_rd.rem) begin
					ev.status = ST_OVERFILL;
				end else begin
					ev.total = total_q - TOTAL_W'(fill_m);
					if (new_rem == '0) begin
						unlink   = 1'b1;
						unl_slot = head_q;
					end else begin
						dw1_en       = 1'b1;
						dw1_addr     = head_q;
						dw1_data.rem = new_rem;
						dw1_mask.rem = '1;
						ev.front_src = FR_SET;
						ev.front_rem = new_rem;
					end
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					ev.status = ST_EMPTY;
				end else if (data_rd.rem != '0) begin
					ev.status = ST_UNFILLED;
				end else begin
					unlink   = 1'b1;
					unl_slot = head_q;
				end
			end
			default: begin
			end
		endcase

		// unlink a slot and push it on the free list
		is_head = (unl_slot == head_q);
		is_tail = (unl_slot == tail_q);
		if (unlink) begin
			if (!is_head) begin
				lw1_en       = 1'b1;
				lw1_addr     = data_rd.prev;
				lw1_data.nxt = l_next;
				lw1_mask.nxt = '1;
			end
			if (!is_tail) begin
				dw1_en        = 1'b1;
				dw1_addr      = l_next;
				dw1_data.prev = data_rd.prev;
				dw1_mask.prev = '1;
			end
			ev.head         = is_head ? l_next : head_q;
			ev.tail         = is_tail ? data_rd.prev : tail_q;
			ev.total        = ev.total - TOTAL_W'(sub_amt);
			ev.free_slot    = unl_slot;
			ev.count        = count_q - CW'(1);
			ev.lw_en        = 1'b1;
			ev.lw_addr      = unl_slot;
			ev.lw_data.used = 1'b0;
			ev.lw_data.nxt  = free_q;
			if (count_q == CW'(1)) begin
				ev.head = '0;
				ev.tail = '0;
			end else if (is_head) begin
				ev.front_src = FR_LOAD;
			end
		end
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs: handshake, RAM ports, commit strobe
	always_comb begin
		req_ready  = 1'b0;
		commit     = 1'b0;
		link_we    = 1'b0;
		link_waddr = plan_q.lw_addr;
		link_wdata = plan_q.lw_data;
		link_wmask = '1;
		link_raddr = la_op;
		data_we    = 1'b0;
		data_waddr = plan_q.dw_addr;
		data_wdata = plan_q.dw_data;
		data_wmask = '1;
		data_raddr = plan_q.nx;
		case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				link_raddr = la_req;
				data_raddr = da_req;
			end
			S_EVAL: begin
				link_we    = lw1_en;
				link_waddr = lw1_addr;
				link_wdata = lw1_data;
				link_wmask = lw1_mask;
				data_we    = dw1_en;
				data_waddr = dw1_addr;
				data_wdata = dw1_data;
				data_wmask = dw1_mask;
				data_raddr = l_next;
			end
			S_DONE: begin
				commit  = out_free;
				link_we = out_free && plan_q.lw_en;
				data_we = out_free && plan_q.dw_en;
			end
			default: begin
			end
		endcase
	end

	// pick the front order after the command
	always_comb begin
		front_id_d  = front_id_q;
		front_rem_d = front_rem_q;
		case (plan_q.front_src)
			FR_KEEP: begin
			end
			FR_SET: begin
				front_id_d  = plan_q.front_id;
				front_rem_d = plan_q.front_rem;
			end
			FR_LOAD: begin
				front_id_d  = data_rd.id;
				front_rem_d = data_rd.rem;
			end
			default: begin
			end
		endcase
	end

	// build the response item
	always_comb begin
		rsp_d                 = '0;
		rsp_d.status          = plan_q.status;
		rsp_d.new_handle      = plan_q.new_handle;
		rsp_d.total_quantity  = plan_q.total;
		rsp_d.order_count     = COUNT_OUT_W'(plan_q.count);
		rsp_d.front_valid     = plan_q.count != '0;
		rsp_d.front_id        = rsp_d.front_valid ? front_id_d : '0;
		rsp_d.front_remaining = rsp_d.front_valid ? QTY_IN_W'(front_rem_d) : '0;
	end

	// control and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= PRICE_W'(1);
			head_q      <= '0;
			tail_q      <= '0;
			free_q      <= '0;
			fresh_q     <= '0;
			count_q     <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			plan_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				level_q <= cfg_data;
			end
			if (state_q == S_EVAL) begin
				plan_q <= ev;
			end
			if (commit) begin
				head_q  <= plan_q.head;
				tail_q  <= plan_q.tail;
				free_q  <= plan_q.free_slot;
				fresh_q <= plan_q.fresh;
				count_q <= plan_q.count;
				total_q <= plan_q.total;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the accepted item, the front order and the response payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q <= req;
		end
		if (commit) begin
			front_id_q  <= front_id_d;
			front_rem_q <= front_rem_d;
			rsp_q       <= rsp_d;
		end
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/plq_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Bit write mask; read returns the old word on a same-address write. No dependencies.
module plq_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wmask,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	// write masked bits, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < W; i++) begin
				if (wmask[i]) begin
					mem[waddr][i] <= wdata[i];
				end
			end
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/plq_checker.sv]
// Port-level checks of the price level order queue core, bound to the queue core.
// Depends on plq_pkg and on the port names of price_level_order_queue_core.
module plq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input plq_pkg::rsp_t rsp
);
	import plq_pkg::*;

	// hold a stalled response item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response item changed while stalled");

	// report an empty queue with all totals and front fields cleared
	a_empty_view: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.front_valid |->
			rsp.order_count == '0 && rsp.total_quantity == '0 &&
			rsp.front_id == '0 && rsp.front_remaining == '0)
		else $error("empty queue reported with nonzero fields");

	// flag empty only when no front order is left
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> !rsp.front_valid)
		else $error("empty status with a front order present");

	// give out a handle only on a successful command
	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.new_handle == '0)
		else $error("handle reported on a failed command");

endmodule

bind price_level_order_queue_core plq_checker u_plq_checker (.*);
